// File: rtl/core/line_segment_orientation_chooser_macros.svh
// Assertion macros shared by the orientation chooser checkers.
`ifndef LINE_SEGMENT_ORIENTATION_CHOOSER_MACROS_SVH
`define LINE_SEGMENT_ORIENTATION_CHOOSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSOC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lsoc_pkg.sv
// Types and constants of the line segment orientation chooser.
package lsoc_pkg;

    localparam int TOL_WIDTH = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_RUN,
        ST_DECIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic {
        PH_HELD,
        PH_INPUT
    } phase_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQUARE,
        DS_ROOT
    } dist_state_t;

    // Operand pair chosen for each of the four distances of one decision.
    typedef enum logic [1:0] {
        DSEL_PREV_START,
        DSEL_END_NEXT,
        DSEL_PREV_END,
        DSEL_START_NEXT
    } dsel_t;

endpackage

// File: rtl/core/line_segment_orientation_chooser.sv
// Top level of the line segment orientation chooser.
//
// Usage: a path arrives one segment word per accepted in_valid/in_ready
// handshake; last_in marks its final segment. The block holds one segment
// back until the start of the next one is known, then sends it on the
// out_valid/out_ready channel, with the endpoints of a line swapped when
// that cuts the travel cost by more than the tolerance (at least 1 LSB).
// A word with last_in set yields up to two output words: the held segment,
// then the final segment itself with last_out set.
// A line's decision runs four Euclidean distances one after another through
// the single bit-serial distance unit (launch, square phase, root phase,
// done); any other segment kind goes straight on to the emit step. The
// decision starts at the accepting edge, or for a final word at the edge
// that loads the held one. One input word is worked at a time; in_ready is
// high only while idle. A stalled receiver holds the output register and
// the block waits in its emit step; nothing is lost. The tolerance register
// is written through cfg_we/cfg_data; the user must write it only while
// idle, as the block itself does not enforce this. Reset empties the hold
// stage, marks path start and sets the tolerance to 1.
module line_segment_orientation_chooser #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          is_line,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic                          last_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_is_line,
    output logic signed [COORD_WIDTH-1:0] out_start_x,
    output logic signed [COORD_WIDTH-1:0] out_start_y,
    output logic signed [COORD_WIDTH-1:0] out_end_x,
    output logic signed [COORD_WIDTH-1:0] out_end_y,
    output logic                          reversed,
    output logic                          last_out,
    input  logic                          cfg_we,
    input  logic [lsoc_pkg::TOL_WIDTH-1:0] cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = W + 2;
    localparam int CW = ((SW > lsoc_pkg::TOL_WIDTH) ? SW : lsoc_pkg::TOL_WIDTH) + 1;

    lsoc_pkg::ctrl_state_t state_reg, state_next;
    lsoc_pkg::phase_t      phase_reg;
    lsoc_pkg::dsel_t       dsel_reg;

    // Input word being worked on.
    logic         in_line_reg, in_last_reg;
    logic [W-1:0] in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;

    // Segment held back until the next start is known.
    logic         held_line_reg;
    logic [W-1:0] held_sx_reg, held_sy_reg, held_ex_reg, held_ey_reg;
    logic         held_valid_reg, at_start_reg, had_held_reg;
    logic [W-1:0] prev_x_reg, prev_y_reg;

    logic [SW-1:0] cur_reg, alt_reg;
    logic          rev_reg;
    logic [lsoc_pkg::TOL_WIDTH-1:0] tol_reg;

    logic         out_valid_reg, out_line_reg, out_rev_reg, out_last_reg;
    logic [W-1:0] out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    logic         accept, out_free, dist_start, dist_done;
    logic [W:0]   dist_val;

    // Segment under decision, its previous end and its next start.
    logic         seg_line;
    logic [W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [W-1:0] p_x, p_y, n_x, n_y;
    logic [W-1:0] op_ax, op_ay, op_bx, op_by;

    logic [lsoc_pkg::TOL_WIDTH-1:0] tol_eff;
    logic [CW-1:0]                  alt_plus_tol;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (phase_reg == lsoc_pkg::PH_HELD)
        begin
            seg_line = held_line_reg;
            seg_sx   = held_sx_reg;
            seg_sy   = held_sy_reg;
            seg_ex   = held_ex_reg;
            seg_ey   = held_ey_reg;
            // First segment of a path stands in for its own previous end.
            p_x      = at_start_reg ? held_sx_reg : prev_x_reg;
            p_y      = at_start_reg ? held_sy_reg : prev_y_reg;
            n_x      = in_sx_reg;
            n_y      = in_sy_reg;
        end
        else
        begin
            seg_line = in_line_reg;
            seg_sx   = in_sx_reg;
            seg_sy   = in_sy_reg;
            seg_ex   = in_ex_reg;
            seg_ey   = in_ey_reg;
            p_x      = had_held_reg ? prev_x_reg : in_sx_reg;
            p_y      = had_held_reg ? prev_y_reg : in_sy_reg;
            // Last segment of a path stands in for the next start.
            n_x      = in_ex_reg;
            n_y      = in_ey_reg;
        end
    end

    always_comb
    begin
        case (dsel_reg)
            lsoc_pkg::DSEL_PREV_START:
            begin
                op_ax = p_x;    op_ay = p_y;    op_bx = seg_sx; op_by = seg_sy;
            end
            lsoc_pkg::DSEL_END_NEXT:
            begin
                op_ax = seg_ex; op_ay = seg_ey; op_bx = n_x;    op_by = n_y;
            end
            lsoc_pkg::DSEL_PREV_END:
            begin
                op_ax = p_x;    op_ay = p_y;    op_bx = seg_ex; op_by = seg_ey;
            end
            lsoc_pkg::DSEL_START_NEXT:
            begin
                op_ax = seg_sx; op_ay = seg_sy; op_bx = n_x;    op_by = n_y;
            end
            default:
            begin
                op_ax = p_x;    op_ay = p_y;    op_bx = seg_sx; op_by = seg_sy;
            end
        endcase
    end

    lsoc_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dist_start),
        .ax       (op_ax),
        .ay       (op_ay),
        .bx       (op_bx),
        .by       (op_by),
        .done     (dist_done),
        .distance (dist_val)
    );

    // A zero tolerance acts as one LSB.
    assign tol_eff      = (tol_reg == '0) ? lsoc_pkg::TOL_WIDTH'(1) : tol_reg;
    assign alt_plus_tol = CW'(alt_reg) + CW'(tol_eff);

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        dist_start = 1'b0;
        case (state_reg)
            lsoc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && (held_valid_reg || last_in))
                begin
                    state_next = lsoc_pkg::ST_START;
                end
            end
            lsoc_pkg::ST_START:
            begin
                state_next = seg_line ? lsoc_pkg::ST_LOAD : lsoc_pkg::ST_EMIT;
            end
            lsoc_pkg::ST_LOAD:
            begin
                dist_start = 1'b1;
                state_next = lsoc_pkg::ST_RUN;
            end
            lsoc_pkg::ST_RUN:
            begin
                if (dist_done)
                begin
                    state_next = (dsel_reg == lsoc_pkg::DSEL_START_NEXT) ?
                                 lsoc_pkg::ST_DECIDE : lsoc_pkg::ST_LOAD;
                end
            end
            lsoc_pkg::ST_DECIDE:
            begin
                state_next = lsoc_pkg::ST_EMIT;
            end
            lsoc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (phase_reg == lsoc_pkg::PH_HELD && in_last_reg) ?
                                 lsoc_pkg::ST_START : lsoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsoc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lsoc_pkg::ST_IDLE;
            held_valid_reg <= 1'b0;
            at_start_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            tol_reg        <= lsoc_pkg::TOL_WIDTH'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            if (state_reg == lsoc_pkg::ST_IDLE && accept && !held_valid_reg && !last_in)
            begin
                // First segment of a path: hold it.
                held_valid_reg <= 1'b1;
                at_start_reg   <= 1'b1;
            end
            if (state_reg == lsoc_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (phase_reg == lsoc_pkg::PH_HELD)
                begin
                    if (!in_last_reg)
                    begin
                        held_valid_reg <= 1'b1;
                        at_start_reg   <= 1'b0;
                    end
                end
                else
                begin
                    held_valid_reg <= 1'b0;
                    at_start_reg   <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lsoc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    in_line_reg  <= is_line;
                    in_sx_reg    <= start_x;
                    in_sy_reg    <= start_y;
                    in_ex_reg    <= end_x;
                    in_ey_reg    <= end_y;
                    in_last_reg  <= last_in;
                    had_held_reg <= held_valid_reg;
                    phase_reg    <= held_valid_reg ? lsoc_pkg::PH_HELD : lsoc_pkg::PH_INPUT;
                    if (!held_valid_reg && !last_in)
                    begin
                        held_line_reg <= is_line;
                        held_sx_reg   <= start_x;
                        held_sy_reg   <= start_y;
                        held_ex_reg   <= end_x;
                        held_ey_reg   <= end_y;
                    end
                end
            end
            lsoc_pkg::ST_START:
            begin
                dsel_reg <= lsoc_pkg::DSEL_PREV_START;
                cur_reg  <= '0;
                alt_reg  <= '0;
                rev_reg  <= 1'b0;
            end
            lsoc_pkg::ST_RUN:
            begin
                if (dist_done)
                begin
                    if (dsel_reg == lsoc_pkg::DSEL_PREV_START ||
                        dsel_reg == lsoc_pkg::DSEL_END_NEXT)
                    begin
                        cur_reg <= cur_reg + SW'(dist_val);
                    end
                    else
                    begin
                        alt_reg <= alt_reg + SW'(dist_val);
                    end
                    dsel_reg <= lsoc_pkg::dsel_t'(dsel_reg + 2'd1);
                end
            end
            lsoc_pkg::ST_DECIDE:
            begin
                rev_reg <= (alt_plus_tol < CW'(cur_reg));
            end
            lsoc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_line_reg <= seg_line;
                    out_rev_reg  <= rev_reg;
                    out_last_reg <= (phase_reg == lsoc_pkg::PH_INPUT);
                    out_sx_reg   <= rev_reg ? seg_ex : seg_sx;
                    out_sy_reg   <= rev_reg ? seg_ey : seg_sy;
                    out_ex_reg   <= rev_reg ? seg_sx : seg_ex;
                    out_ey_reg   <= rev_reg ? seg_sy : seg_ey;
                    prev_x_reg   <= rev_reg ? seg_sx : seg_ex;
                    prev_y_reg   <= rev_reg ? seg_sy : seg_ey;
                    if (phase_reg == lsoc_pkg::PH_HELD)
                    begin
                        if (in_last_reg)
                        begin
                            // Advance to the final segment of the path.
                            phase_reg <= lsoc_pkg::PH_INPUT;
                        end
                        else
                        begin
                            held_line_reg <= in_line_reg;
                            held_sx_reg   <= in_sx_reg;
                            held_sy_reg   <= in_sy_reg;
                            held_ex_reg   <= in_ex_reg;
                            held_ey_reg   <= in_ey_reg;
                        end
                    end
                end
            end
            default:
            begin
                rev_reg <= rev_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_is_line = out_line_reg;
    assign out_start_x = out_sx_reg;
    assign out_start_y = out_sy_reg;
    assign out_end_x   = out_ex_reg;
    assign out_end_y   = out_ey_reg;
    assign reversed    = out_rev_reg;
    assign last_out    = out_last_reg;

endmodule

// File: rtl/core/lsoc_dist.sv
// Bit-serial Euclidean distance: shift-add squares, then digit-by-digit square root.
module lsoc_dist #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COORD_WIDTH-1:0] ax,
    input  logic [COORD_WIDTH-1:0] ay,
    input  logic [COORD_WIDTH-1:0] bx,
    input  logic [COORD_WIDTH-1:0] by,
    output logic                   done,
    output logic [COORD_WIDTH:0]   distance
);

    localparam int W    = COORD_WIDTH;
    localparam int SQW  = 2 * W + 2;
    localparam int RW   = W + 4;
    localparam int CNTW = $clog2(W + 2);

    lsoc_pkg::dist_state_t state_reg, state_next;

    logic [SQW-1:0]  mcx_reg, mcy_reg, acc_reg;
    logic [W-1:0]    mpx_reg, mpy_reg;
    logic [RW-1:0]   rem_reg;
    logic [W:0]      root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;

    logic [W-1:0]    ua, ub, va, vb, dx, dy;
    logic [SQW-1:0]  addx, addy;
    logic [RW-1:0]   rem_sh, trial;
    logic            fits;

    // Offset binary makes unsigned order match signed order.
    assign ua = ax ^ {1'b1, {(W-1){1'b0}}};
    assign ub = bx ^ {1'b1, {(W-1){1'b0}}};
    assign va = ay ^ {1'b1, {(W-1){1'b0}}};
    assign vb = by ^ {1'b1, {(W-1){1'b0}}};
    assign dx = (ua > ub) ? (ua - ub) : (ub - ua);
    assign dy = (va > vb) ? (va - vb) : (vb - va);

    assign addx = mpx_reg[0] ? mcx_reg : '0;
    assign addy = mpy_reg[0] ? mcy_reg : '0;

    assign rem_sh = {rem_reg[RW-3:0], acc_reg[SQW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsoc_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    state_next = lsoc_pkg::DS_SQUARE;
                end
            end
            lsoc_pkg::DS_SQUARE:
            begin
                if (cnt_reg == CNTW'(W - 1))
                begin
                    state_next = lsoc_pkg::DS_ROOT;
                end
            end
            lsoc_pkg::DS_ROOT:
            begin
                if (cnt_reg == CNTW'(W))
                begin
                    state_next = lsoc_pkg::DS_IDLE;
                end
            end
            default:
            begin
                state_next = lsoc_pkg::DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsoc_pkg::DS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == lsoc_pkg::DS_ROOT) && (cnt_reg == CNTW'(W));
            if (state_reg != state_next)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg != lsoc_pkg::DS_IDLE)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lsoc_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    mpx_reg  <= dx;
                    mpy_reg  <= dy;
                    mcx_reg  <= SQW'(dx);
                    mcy_reg  <= SQW'(dy);
                    acc_reg  <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            lsoc_pkg::DS_SQUARE:
            begin
                // One multiplier bit of each square per cycle.
                acc_reg <= acc_reg + addx + addy;
                mcx_reg <= {mcx_reg[SQW-2:0], 1'b0};
                mcy_reg <= {mcy_reg[SQW-2:0], 1'b0};
                mpx_reg <= {1'b0, mpx_reg[W-1:1]};
                mpy_reg <= {1'b0, mpy_reg[W-1:1]};
            end
            lsoc_pkg::DS_ROOT:
            begin
                // One root bit per cycle from the next two radicand bits.
                acc_reg  <= {acc_reg[SQW-3:0], 2'b00};
                rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[W-1:0], fits};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign distance = root_reg;

endmodule

// File: rtl/core/lsoc_checker.sv
// Port-level checker for the orientation chooser, bound to the top level.
`include "line_segment_orientation_chooser_macros.svh"

module lsoc_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          last_in,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_is_line,
    input logic signed [COORD_WIDTH-1:0] out_start_x,
    input logic signed [COORD_WIDTH-1:0] out_start_y,
    input logic signed [COORD_WIDTH-1:0] out_end_x,
    input logic signed [COORD_WIDTH-1:0] out_end_y,
    input logic                          reversed,
    input logic                          last_out
);

    // Hold a stalled output word.
    `LSOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_start_x) && $stable(out_end_x) && $stable(reversed) && $stable(last_out), "output word changed while stalled")

    // Only lines are ever swapped.
    `LSOC_ASSERT_SAME(a_rev_line, out_valid && reversed, out_is_line, "non-line segment reported as reversed")

    // A swap must gain something, so a degenerate line is never swapped.
    `LSOC_ASSERT_SAME(a_rev_gain, out_valid && reversed, (out_start_x != out_end_x) || (out_start_y != out_end_y), "zero-length line reversed")

    // A final segment always produces output, so the block stops taking input.
    `LSOC_ASSERT_NEXT(a_last_busy, in_valid && in_ready && last_in, !in_ready, "input taken while final segment pending")

endmodule

bind line_segment_orientation_chooser lsoc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lsoc_checker (.*);
